[rtl/core/ipv4th_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4th_pkg
// Shared types and constants for the IPv4 tunnel header insertion block.
// ----------------------------------------------------------------------------
package ipv4th_pkg;

  localparam int TBL_ENTRIES = 16;
  localparam int TBL_IDX_W   = (TBL_ENTRIES > 1) ? $clog2(TBL_ENTRIES) : 1;

  localparam int HOLD_BYTES  = 34;
  localparam int ETH_HDR     = 14;
  localparam int MAC_BYTES   = 12;
  localparam int CNT_W       = 6;
  localparam int HDR_AW      = CNT_W;

  // encapsulated header layout, in beats of the release burst
  localparam int ETYPE_HI_POS = 12;
  localparam int ETYPE_LO_POS = 13;
  localparam int ZERO_POS     = 14;
  localparam int VALUE_POS    = 26;
  localparam int TAIL_POS     = 34;
  localparam int TAIL_SHIFT   = 20;   // burst beat minus held byte index in the tail
  localparam int ENCAP_BEATS  = 54;

  localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
  localparam logic [15:0] ETYPE_TUN_RST  = 16'h1234;

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;

  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_DROP   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ST_UPDATED  = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [2:0] {
    FM_COLLECT = 3'b001,
    FM_PASS    = 3'b010,
    FM_ENCAP   = 3'b100
  } frame_mode_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  frame_byte;
    logic        frame_last;
    logic [31:0] table_key;
    logic [63:0] table_value;
  } ipv4th_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       frame_end;
    logic       encapsulated;
    logic [1:0] table_status;
    logic       run_last;
  } ipv4th_out_t;

  // key table lookup result
  typedef struct packed {
    logic                 hit;
    logic [TBL_IDX_W-1:0] hit_idx;
    logic                 free_ok;
    logic [TBL_IDX_W-1:0] free_idx;
  } ipv4th_lkup_t;

  // key table update request
  typedef struct packed {
    logic                 set;
    logic                 clr;
    logic [TBL_IDX_W-1:0] idx;
    logic [31:0]          key;
  } ipv4th_upd_t;

  // one result beat waiting for the output register
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] lit;
    logic       from_ram;
    logic       frame_end;
    logic       encap;
    logic [1:0] status;
    logic       run_last;
  } ipv4th_beat_t;

endpackage

[rtl/core/ipv4th_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4th_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ipv4th_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/ipv4th_keytab.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4th_keytab
// Tunnel key table: keys and valid bits with parallel match and free search.
// ----------------------------------------------------------------------------
module ipv4th_keytab (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [31:0]              lk_key,
  output ipv4th_pkg::ipv4th_lkup_t lk,
  input  ipv4th_pkg::ipv4th_upd_t  upd
);

  import ipv4th_pkg::*;

  logic [31:0]            key_r   [TBL_ENTRIES];
  logic [TBL_ENTRIES-1:0] valid_r;
  logic [TBL_ENTRIES-1:0] valid_nxt;

  // downward scan so the lowest entry wins
  always_comb begin
    lk = '0;
    for (int i = TBL_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && key_r[i] == lk_key) begin
        lk.hit     = 1'b1;
        lk.hit_idx = TBL_IDX_W'(i);
      end
      if (!valid_r[i]) begin
        lk.free_ok  = 1'b1;
        lk.free_idx = TBL_IDX_W'(i);
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (upd.set) begin
      valid_nxt[upd.idx] = 1'b1;
    end else if (upd.clr) begin
      valid_nxt[upd.idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.set) begin
      key_r[upd.idx] <= upd.key;
    end
  end

  a_set_free: assert property (@(posedge clk) disable iff (!rst_n)
    upd.set |-> !valid_r[upd.idx])
    else $error("insert into an occupied entry");

  a_clr_valid: assert property (@(posedge clk) disable iff (!rst_n)
    upd.clr |-> valid_r[upd.idx])
    else $error("delete of an empty entry");

endmodule

[rtl/core/ipv4_tunnel_header_insert.sv]
`timescale 1ns / 1ps
// Path: a pass-through byte, drop or status result is registered in the beat stage and then in
// the output register; a header release first sets the burst sequencer, which then feeds both.
// Throughput: one item per cycle while the output is not stalled and no release runs. The release
// after byte 13 or 33 plays 14, 34 or 54 beats, one a cycle unless stalled; input is held until it ends.
// Reset: synchronous; clears frame state, burst sequencer and table valid bits, and
// loads the tunnel ethertype with 0x1234. RAM contents are not cleared.
// ----------------------------------------------------------------------------
// ipv4_tunnel_header_insert
// Buffers frame headers, looks up the IPv4 destination and inserts a tunnel header.
// ----------------------------------------------------------------------------
module ipv4_tunnel_header_insert (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  ipv4th_pkg::ipv4th_in_t  in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output ipv4th_pkg::ipv4th_out_t out_data,
  input  logic                    cfg_we,
  input  logic [15:0]             cfg_wdata
);

  import ipv4th_pkg::*;

  // frame state
  frame_mode_t      mode_r, mode_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             encap_r, encap_nxt;
  logic [23:0]      hist_r, hist_nxt;
  logic [15:0]      etype_r;

  // release burst sequencer
  logic             burst_r, burst_nxt;
  logic             bencap_r, bencap_nxt;
  logic             bfend_r, bfend_nxt;
  logic [CNT_W-1:0] blast_r, blast_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;

  // beat stage and output register
  ipv4th_beat_t b_r, b_nxt, beat;
  logic         b_valid_r, b_valid_nxt, beat_v;
  ipv4th_out_t  out_r;
  logic         out_valid_r;

  logic             out_free, advance, acc, bfinal;
  logic [CNT_W-1:0] c, vk;
  logic [2:0]       vsel;
  logic [15:0]      eth;

  // memories and table
  logic              hdr_we, hdr_re;
  logic [HDR_AW-1:0] hdr_raddr;
  logic [7:0]        hdr_rdata;
  logic              val_we, val_re;
  logic [TBL_IDX_W-1:0] val_waddr;
  logic [63:0]       val_rdata;
  logic [31:0]       lk_key;
  ipv4th_lkup_t      lk;
  ipv4th_upd_t       upd;

  ipv4th_ram #(.WIDTH(8), .DEPTH(HOLD_BYTES)) u_hdr_ram (
    .clk   (clk),
    .we    (hdr_we),
    .waddr (cnt_r),
    .wdata (in_data.frame_byte),
    .re    (hdr_re),
    .raddr (hdr_raddr),
    .rdata (hdr_rdata)
  );

  ipv4th_ram #(.WIDTH(64), .DEPTH(TBL_ENTRIES)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (in_data.table_value),
    .re    (val_re),
    .raddr (lk.hit_idx),
    .rdata (val_rdata)
  );

  ipv4th_keytab u_keytab (
    .clk    (clk),
    .rst_n  (rst_n),
    .lk_key (lk_key),
    .lk     (lk),
    .upd    (upd)
  );

  always_comb begin
    out_free = !out_valid_r || out_ready;
    advance  = !b_valid_r || out_free;
    in_ready = advance && !burst_r;
    acc      = in_valid && in_ready;
    c        = cnt_r + CNT_W'(1);
    eth      = {hist_r[7:0], in_data.frame_byte};
    lk_key   = (in_data.op == OP_BYTE) ? {hist_r, in_data.frame_byte} : in_data.table_key;
    bfinal   = bencap_r ? (idx_r == CNT_W'(ENCAP_BEATS - 1)) : (idx_r == blast_r);
    vk       = idx_r - CNT_W'(VALUE_POS);
    vsel     = 3'd7 - vk[2:0];
  end

  always_comb begin
    mode_nxt   = mode_r;
    cnt_nxt    = cnt_r;
    encap_nxt  = encap_r;
    hist_nxt   = hist_r;
    burst_nxt  = burst_r;
    bencap_nxt = bencap_r;
    bfend_nxt  = bfend_r;
    blast_nxt  = blast_r;
    idx_nxt    = idx_r;
    beat_v     = 1'b0;
    beat       = '0;
    hdr_we     = 1'b0;
    hdr_re     = 1'b0;
    hdr_raddr  = idx_r;
    val_we     = 1'b0;
    val_re     = 1'b0;
    val_waddr  = lk.hit_idx;
    upd        = '0;
    upd.key    = in_data.table_key;

    if (burst_r) begin
      if (advance) begin
        beat_v = 1'b1;
        beat.kind = KIND_BYTE;
        beat.encap = bencap_r;
        beat.run_last = bfinal;
        beat.frame_end = bfend_r && bfinal;
        if (!bencap_r || idx_r < CNT_W'(MAC_BYTES)) begin
          beat.from_ram = 1'b1;
        end else if (idx_r == CNT_W'(ETYPE_HI_POS)) begin
          beat.lit = etype_r[15:8];
        end else if (idx_r == CNT_W'(ETYPE_LO_POS)) begin
          beat.lit = etype_r[7:0];
        end else if (idx_r < CNT_W'(VALUE_POS)) begin
          beat.lit = 8'h00;
        end else if (idx_r < CNT_W'(TAIL_POS)) begin
          beat.lit = val_rdata[{vsel, 3'b000} +: 8];
        end else begin
          beat.from_ram = 1'b1;
          hdr_raddr = idx_r - CNT_W'(TAIL_SHIFT);
        end
        hdr_re  = beat.from_ram;
        idx_nxt = idx_r + CNT_W'(1);
        if (bfinal) begin
          burst_nxt = 1'b0;
        end
      end
    end else if (acc) begin
      case (in_data.op)
        OP_BYTE: begin
          if (mode_r != FM_COLLECT) begin
            beat_v = 1'b1;
            beat.kind = KIND_BYTE;
            beat.lit = in_data.frame_byte;
            beat.frame_end = in_data.frame_last;
            beat.encap = encap_r;
            beat.run_last = 1'b1;
            if (in_data.frame_last) begin
              mode_nxt  = FM_COLLECT;
              cnt_nxt   = '0;
              encap_nxt = 1'b0;
            end
          end else begin
            hdr_we   = 1'b1;
            hist_nxt = {hist_r[15:0], in_data.frame_byte};
            cnt_nxt  = c;
            if (c == CNT_W'(ETH_HDR) && eth != ETYPE_IPV4) begin
              burst_nxt  = 1'b1;
              bencap_nxt = 1'b0;
              blast_nxt  = CNT_W'(ETH_HDR - 1);
              bfend_nxt  = in_data.frame_last;
              idx_nxt    = '0;
              mode_nxt   = FM_PASS;
            end else if (c == CNT_W'(HOLD_BYTES)) begin
              burst_nxt = 1'b1;
              bfend_nxt = in_data.frame_last;
              idx_nxt   = '0;
              if (lk.hit) begin
                val_re     = 1'b1;
                bencap_nxt = 1'b1;
                mode_nxt   = FM_ENCAP;
                encap_nxt  = 1'b1;
              end else begin
                bencap_nxt = 1'b0;
                blast_nxt  = CNT_W'(HOLD_BYTES - 1);
                mode_nxt   = FM_PASS;
              end
            end else if (in_data.frame_last) begin
              // runt frame: discard what was held
              beat_v = 1'b1;
              beat.kind = KIND_DROP;
              beat.run_last = 1'b1;
            end
            if (in_data.frame_last) begin
              mode_nxt  = FM_COLLECT;
              cnt_nxt   = '0;
              encap_nxt = 1'b0;
            end
          end
        end
        OP_SET: begin
          beat_v = 1'b1;
          beat.kind = KIND_STATUS;
          beat.run_last = 1'b1;
          if (lk.hit) begin
            val_we = 1'b1;
            beat.status = ST_UPDATED;
          end else if (lk.free_ok) begin
            val_we    = 1'b1;
            val_waddr = lk.free_idx;
            upd.set   = 1'b1;
            upd.idx   = lk.free_idx;
            beat.status = ST_INSERTED;
          end else begin
            beat.status = ST_FULL;
          end
        end
        OP_DEL: begin
          beat_v = 1'b1;
          beat.kind = KIND_STATUS;
          beat.run_last = 1'b1;
          if (lk.hit) begin
            upd.clr = 1'b1;
            upd.idx = lk.hit_idx;
            beat.status = ST_UPDATED;
          end else begin
            beat.status = ST_NOTFOUND;
          end
        end
        default: begin
        end
      endcase
    end

    b_nxt       = b_r;
    b_valid_nxt = b_valid_r;
    if (advance) begin
      b_nxt       = beat;
      b_valid_nxt = beat_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= FM_COLLECT;
      cnt_r       <= '0;
      encap_r     <= 1'b0;
      burst_r     <= 1'b0;
      idx_r       <= '0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      etype_r     <= ETYPE_TUN_RST;
    end else begin
      mode_r    <= mode_nxt;
      cnt_r     <= cnt_nxt;
      encap_r   <= encap_nxt;
      burst_r   <= burst_nxt;
      idx_r     <= idx_nxt;
      b_valid_r <= b_valid_nxt;
      if (out_free) begin
        out_valid_r <= b_valid_r;
      end
      if (cfg_we) begin
        etype_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    hist_r   <= hist_nxt;
    bencap_r <= bencap_nxt;
    bfend_r  <= bfend_nxt;
    blast_r  <= blast_nxt;
    b_r      <= b_nxt;
    if (out_free) begin
      out_r.kind         <= b_r.kind;
      out_r.out_byte     <= b_r.from_ram ? hdr_rdata : b_r.lit;
      out_r.frame_end    <= b_r.frame_end;
      out_r.encapsulated <= b_r.encap;
      out_r.table_status <= b_r.status;
      out_r.run_last     <= b_r.run_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // header RAM data must hold while its beat waits
  a_hdr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && b_r.from_ram && !out_free) |-> !hdr_re)
    else $error("header read overwrote pending data");

  a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    (burst_r && advance && bfinal) |=> !burst_r)
    else $error("release burst overran");

  a_encap_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == FM_ENCAP) |-> encap_r)
    else $error("encapsulating without flag");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && b_r.kind != KIND_BYTE) |-> b_r.run_last)
    else $error("single result without run_last");

endmodule
